// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpm assertion failed");

// The expression must hold in every cycle out of reset.
`define WPM_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("wpm assertion failed");

`endif

// ----- rtl/wpm_pkg.sv -----
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared constants and types of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_TEXT   = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  typedef struct packed {
    logic       acc;
    logic [1:0] func;
    logic [7:0] ch;
  } wpm_ctl_t;

  typedef struct packed {
    logic fwd;
    logic app_act;
    logic app_init;
  } wpm_link_t;

endpackage

`default_nettype wire

// ----- rtl/wpm_if.sv -----
// ----------------------------------------------------------------------------
// wpm_in_if / wpm_out_if
// Valid-ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] ch;
  modport source (output valid, output func, output ch, input ready);
  modport sink (input valid, input func, input ch, output ready);
endinterface

interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflow;
  modport source (output valid, output matched, output overflow, input ready);
  modport sink (input valid, input matched, input overflow, output ready);
endinterface

`default_nettype wire

// ----- rtl/wildcard_pattern_matcher.sv -----
// A finish word's result word is registered in the output register, or in a
// spare result register while the output stalls; so input flows on while one
// result word waits. One word is accepted per cycle while the spare is empty;
// every position cell updates in parallel and the star closure ripples through
// the cell row within the same cycle. Reset (synchronous, active low) empties
// the pattern, clears the overflow flag and leaves only position zero reachable.
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Streams text bytes against a stored pattern with '?' and '*' wildcards.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_matcher
  import wpm_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  wpm_in_if.sink    in_if,
  wpm_out_if.source out_if
);

  `include "assert_macros.svh"

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               ovf_r, ovf_nxt;
  logic               tail_act_r, tail_act_nxt;
  logic               tail_init_r, tail_init_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_matched_r, out_matched_nxt;
  logic               out_overflow_r, out_overflow_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  logic               skid_matched_r, skid_overflow_r;
  logic               in_rdy, acc, fin, out_free;
  wpm_ctl_t           ctl;
  wpm_link_t          lnk [MAX_PATTERN+1];
  logic [MAX_PATTERN:0] act_vec;

  assign in_rdy      = !skid_valid_r;
  assign in_if.ready = in_rdy;
  assign acc         = in_if.valid && in_rdy;
  assign fin         = acc && in_if.func == FUNC_FINISH;
  assign out_free    = !out_valid_r || out_if.ready;

  assign ctl.acc  = acc;
  assign ctl.func = in_if.func;
  assign ctl.ch   = in_if.ch;

  assign lnk[0] = '0;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    wpm_cell #(
      .IDX   (i),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .len     (len_r),
      .lnk_in  (lnk[i]),
      .lnk_out (lnk[i+1]),
      .act     (act_vec[i])
    );
  end

  assign act_vec[MAX_PATTERN] = tail_act_r;

  always_comb begin
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    tail_act_nxt  = tail_act_r;
    tail_init_nxt = tail_init_r;
    if (acc) begin
      unique case (in_if.func)
        FUNC_APPEND: begin
          if (len_r == LEN_MAX) begin
            ovf_nxt = 1'b1;
          end else begin
            len_nxt = len_r + 1'b1;
          end
          tail_act_nxt  = tail_act_r | lnk[MAX_PATTERN].app_act;
          tail_init_nxt = tail_init_r | lnk[MAX_PATTERN].app_init;
        end
        FUNC_TEXT:   tail_act_nxt = lnk[MAX_PATTERN].fwd;
        FUNC_FINISH: tail_act_nxt = tail_init_r;
        FUNC_CLEAR: begin
          len_nxt       = '0;
          ovf_nxt       = 1'b0;
          tail_act_nxt  = 1'b0;
          tail_init_nxt = 1'b0;
        end
        default: len_nxt = len_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_matched_nxt  = out_matched_r;
    out_overflow_nxt = out_overflow_r;
    skid_valid_nxt   = skid_valid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt    = 1'b1;
        out_matched_nxt  = skid_matched_r;
        out_overflow_nxt = skid_overflow_r;
        skid_valid_nxt   = 1'b0;
      end else begin
        out_valid_nxt    = fin;
        out_matched_nxt  = act_vec[len_r];
        out_overflow_nxt = ovf_r;
      end
    end else if (fin) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= '0;
      ovf_r        <= 1'b0;
      tail_act_r   <= 1'b0;
      tail_init_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      len_r        <= len_nxt;
      ovf_r        <= ovf_nxt;
      tail_act_r   <= tail_act_nxt;
      tail_init_r  <= tail_init_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_matched_r  <= out_matched_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  always_ff @(posedge clk) begin
    if (fin && !out_free) begin
      skid_matched_r  <= act_vec[len_r];
      skid_overflow_r <= ovf_r;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.matched  = out_matched_r;
  assign out_if.overflow = out_overflow_r;

  `WPM_ASSERT_NEXT(a_clear_resets, acc && in_if.func == FUNC_CLEAR, len_r == '0 && !ovf_r)
  `WPM_ASSERT_SAME(a_ovf_source, $rose(ovf_r), $past(acc && in_if.func == FUNC_APPEND && len_r == LEN_MAX))
  `WPM_ASSERT_NEXT(a_finish_result, acc && in_if.func == FUNC_FINISH, out_valid_r)
  `WPM_ASSERT_ALWAYS(a_no_reach_past_end, ((act_vec >> len_r) >> 1) == '0)

endmodule

`default_nettype wire

// ----- rtl/wpm_cell.sv -----
// ----------------------------------------------------------------------------
// wpm_cell
// One pattern position: holds its pattern byte, its reachable bit and its
// bit of the start set, and passes reach and closure to the next position.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_cell
  import wpm_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int LEN_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire wpm_ctl_t         ctl,
  input  wire logic [LEN_W-1:0] len,
  input  wire wpm_link_t        lnk_in,
  output wpm_link_t             lnk_out,
  output logic                  act
);

  localparam logic [LEN_W-1:0] MY_POS = LEN_W'(IDX);
  localparam logic RST_BIT = (IDX == 0);

  logic [7:0] pat_r;
  logic       act_r, act_nxt;
  logic       init_r, init_nxt;
  logic       in_pat, is_tail, star, hit, clo, ch_star;

  always_comb begin
    in_pat  = MY_POS < len;
    is_tail = MY_POS == len;
    star    = pat_r == STAR_BYTE;
    hit     = (pat_r == ANY_BYTE) || (pat_r == ctl.ch);
    ch_star = ctl.ch == STAR_BYTE;
    clo     = (act_r & star & in_pat) | lnk_in.fwd;

    lnk_out.fwd      = in_pat & ((act_r & hit & ~star) | (clo & star));
    lnk_out.app_act  = is_tail & ch_star & act_r;
    lnk_out.app_init = is_tail & ch_star & init_r;
  end

  always_comb begin
    act_nxt  = act_r;
    init_nxt = init_r;
    if (ctl.acc) begin
      unique case (ctl.func)
        FUNC_APPEND: begin
          act_nxt  = act_r | lnk_in.app_act;
          init_nxt = init_r | lnk_in.app_init;
        end
        FUNC_TEXT:   act_nxt = clo;
        FUNC_FINISH: act_nxt = init_r;
        FUNC_CLEAR: begin
          act_nxt  = RST_BIT;
          init_nxt = RST_BIT;
        end
        default: act_nxt = act_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= RST_BIT;
      init_r <= RST_BIT;
    end else begin
      act_r  <= act_nxt;
      init_r <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc && ctl.func == FUNC_APPEND && is_tail) begin
      pat_r <= ctl.ch;
    end
  end

  assign act = act_r;

endmodule

`default_nettype wire

// ----- tb/sv/wildcard_pattern_matcher_tb.sv -----
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_tb
// Drives pattern, text, finish and clear words into the matcher and checks
// every result word against a position-set predictor kept in the bench.
// A short directed run covers empty patterns, wildcard bytes in the text
// and appends during text. Random sessions then load patterns, including
// overflowing ones, and feed matching or corrupted text. Four handshake
// phases run: no idling, a mostly idle sender, a mostly stalled receiver,
// and light idling on both sides.
// ----------------------------------------------------------------------------

module wildcard_pattern_matcher_tb;
  import wpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAT_CAP         = 32;
  localparam int ITEMS_PER_PHASE = 258;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] ch;
  } match_word_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } match_res_t;

  logic clk;
  logic rst_n;

  wpm_in_if  in_bus ();
  wpm_out_if out_bus ();

  wildcard_pattern_matcher #(
    .MAX_PATTERN(PAT_CAP)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_bus),
    .out_if(out_bus)
  );

  match_word_t feed_words[$];
  match_res_t  match_results_q[$];

  logic [7:0]       pat_mem [PAT_CAP];
  int               fill_len;
  logic [PAT_CAP:0] reach;
  bit               pat_overflow;

  int send_idle_pct;
  int recv_stall_pct;
  int words_queued;
  int mismatches;
  int cycle_cnt;
  bit in_taken;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [PAT_CAP:0] star_closure(logic [PAT_CAP:0] v);
    for (int i = 0; i < PAT_CAP; i++) begin
      if (i < fill_len && v[i] && pat_mem[i] == STAR_BYTE) begin
        v[i+1] = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic void match_step(logic [1:0] func, logic [7:0] ch);
    logic [PAT_CAP:0] cur;
    logic [PAT_CAP:0] nxt;
    case (func)
      FUNC_APPEND: begin
        if (fill_len < PAT_CAP) begin
          pat_mem[fill_len] = ch;
          fill_len++;
        end else begin
          pat_overflow = 1'b1;
        end
      end
      FUNC_TEXT: begin
        cur = star_closure(reach);
        nxt = '0;
        for (int i = 0; i < PAT_CAP; i++) begin
          if (i < fill_len && cur[i]) begin
            if (pat_mem[i] == STAR_BYTE) begin
              nxt[i] = 1'b1;
            end else if (pat_mem[i] == ANY_BYTE || pat_mem[i] == ch) begin
              nxt[i+1] = 1'b1;
            end
          end
        end
        reach = star_closure(nxt);
      end
      FUNC_FINISH: begin
        cur = star_closure(reach);
        match_results_q.push_back('{matched: cur[fill_len], overflow: pat_overflow});
        reach = 1;
      end
      default: begin
        fill_len = 0;
        pat_overflow = 1'b0;
        reach = 1;
      end
    endcase
  endfunction

  task automatic add_word(input logic [1:0] func, input logic [7:0] ch);
    feed_words.push_back('{func: func, ch: ch});
    words_queued++;
  endtask

  function automatic logic [7:0] pick_pattern_byte();
    int r;
    r = $urandom_range(99);
    if (r < 30) return STAR_BYTE;
    if (r < 50) return ANY_BYTE;
    if (r < 90) return r[0] ? 8'h61 : 8'h62;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 80) return r[0] ? 8'h61 : 8'h62;
    return 8'($urandom_range(255));
  endfunction

  // One session clears the pattern, loads a new one and runs a few texts
  // against it; a minority of sessions are plain random words instead.
  task automatic gen_session(input bit long_pattern);
    logic [7:0] pat[$];
    logic [7:0] txt[$];
    int         r;
    int         len;
    int         n;
    bit         append_mid;
    r = $urandom_range(99);
    if (!long_pattern && r < 12) begin
      n = $urandom_range(1, 6);
      repeat (n) add_word(2'($urandom_range(3)), 8'($urandom_range(255)));
      return;
    end
    add_word(FUNC_CLEAR, 8'($urandom_range(255)));
    r = $urandom_range(99);
    if (long_pattern || r < 5) begin
      len = $urandom_range(31, 36);
    end else if (r < 17) begin
      len = $urandom_range(7, 30);
    end else begin
      len = $urandom_range(0, 6);
    end
    for (int i = 0; i < len; i++) begin
      pat.push_back(pick_pattern_byte());
      add_word(FUNC_APPEND, pat[i]);
    end
    n = $urandom_range(1, 3);
    repeat (n) begin
      txt.delete();
      foreach (pat[i]) begin
        if (i < PAT_CAP) begin
          if (pat[i] == STAR_BYTE) begin
            repeat ($urandom_range(0, 2)) txt.push_back(pick_text_byte());
          end else if (pat[i] == ANY_BYTE) begin
            txt.push_back(8'($urandom_range(255)));
          end else begin
            txt.push_back(pat[i]);
          end
        end
      end
      if ($urandom_range(99) < 30) begin
        case ($urandom_range(2))
          0: if (txt.size() > 0) txt[$urandom_range(txt.size() - 1)] = pick_text_byte();
          1: if (txt.size() > 0) txt.delete(txt.size() - 1);
          default: txt.push_back(pick_text_byte());
        endcase
      end
      append_mid = $urandom_range(99) < 8;
      foreach (txt[i]) begin
        if (append_mid && i == txt.size() / 2) add_word(FUNC_APPEND, pick_pattern_byte());
        add_word(FUNC_TEXT, txt[i]);
      end
      add_word(FUNC_FINISH, 8'($urandom_range(255)));
    end
  endtask

  always @(posedge clk) begin
    in_taken = rst_n && in_bus.valid && in_bus.ready;
    if (in_taken) match_step(in_bus.func, in_bus.ch);
  end

  always @(posedge clk) begin
    match_res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (match_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word: matched=%0b overflow=%0b",
                   out_bus.matched, out_bus.overflow);
        end
      end else begin
        want = match_results_q.pop_front();
        if (out_bus.matched !== want.matched || out_bus.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected matched=%0b overflow=%0b, got %0b %0b",
                     want.matched, want.overflow, out_bus.matched, out_bus.overflow);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    match_word_t w;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (feed_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = feed_words.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.func  <= w.func;
        in_bus.ch    <= w.ch;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_bus.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.func    = FUNC_APPEND;
    in_bus.ch      = 8'h00;
    out_bus.ready  = 1'b0;
    rst_n          = 1'b0;
    fill_len       = 0;
    reach          = 1;
    pat_overflow   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    words_queued   = 0;
    mismatches     = 0;
    cycle_cnt      = 0;
    in_taken       = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      words_queued = 0;
      if (ph == 0) begin
        add_word(FUNC_FINISH, 8'h00);
        add_word(FUNC_TEXT, 8'h00);
        add_word(FUNC_FINISH, 8'hFF);
        add_word(FUNC_APPEND, 8'hFF);
        add_word(FUNC_APPEND, STAR_BYTE);
        add_word(FUNC_APPEND, ANY_BYTE);
        add_word(FUNC_APPEND, 8'h00);
        add_word(FUNC_TEXT, 8'hFF);
        add_word(FUNC_TEXT, STAR_BYTE);
        add_word(FUNC_TEXT, ANY_BYTE);
        add_word(FUNC_TEXT, 8'h00);
        add_word(FUNC_FINISH, 8'h00);
        add_word(FUNC_TEXT, 8'hFF);
        add_word(FUNC_TEXT, 8'h00);
        add_word(FUNC_FINISH, 8'h00);
        add_word(FUNC_CLEAR, 8'hFF);
        add_word(FUNC_APPEND, STAR_BYTE);
        add_word(FUNC_FINISH, 8'h00);
        add_word(FUNC_TEXT, 8'h55);
        add_word(FUNC_APPEND, 8'hAA);
        add_word(FUNC_TEXT, 8'hAA);
        add_word(FUNC_FINISH, 8'h00);
        add_word(FUNC_CLEAR, 8'h00);
        gen_session(1'b1);
      end
      while (words_queued < ITEMS_PER_PHASE) gen_session(1'b0);
      while (feed_words.size() != 0 || in_bus.valid || match_results_q.size() != 0) begin
        @(posedge clk);
      end
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && match_results_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
